### hdl/rwb_pkg.sv
// Shared types and codes for the read-ahead / write-combining buffer controller.
`timescale 1ns / 1ps

package rwb_pkg;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_REPLY = 2'd3
    } cmd_t;

    // Result actions carried on the output tuser
    typedef enum logic [2:0] {
        ACT_BWRITE = 3'd0,
        ACT_DREAD  = 3'd1,
        ACT_FILL   = 3'd2,
        ACT_SERVE  = 3'd3,
        ACT_STASH  = 3'd4,
        ACT_DONE   = 3'd5,
        ACT_FAIL   = 3'd6,
        ACT_BUSY   = 3'd7
    } action_t;

    // Which backend reply the controller is waiting for
    typedef enum logic [6:0] {
        W_NONE        = 7'b0000001,
        W_FLUSH_READ  = 7'b0000010,
        W_FLUSH_WRITE = 7'b0000100,
        W_THROUGH     = 7'b0001000,
        W_DIRECT      = 7'b0010000,
        W_FILL        = 7'b0100000,
        W_FLUSH_CMD   = 7'b1000000
    } await_t;

    // Configuration register indexes
    localparam logic [1:0] REG_DIRECT_ONLY = 2'd0;
    localparam logic [1:0] REG_WINDOW_SIZE = 2'd1;
    localparam logic [1:0] REG_RUN_SIZE    = 2'd2;

    localparam int OFF_W  = 63;
    localparam int LEN_W  = 32;
    localparam int SIZE_W = 17;
    localparam int IDX_W  = 16;

    typedef struct packed {
        cmd_t              cmd;
        logic [OFF_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
        logic              reply_ok;
        logic [LEN_W-1:0]  reply_count;
    } item_t;

    typedef struct packed {
        action_t           action;
        logic [OFF_W-1:0]  out_offset;
        logic [LEN_W-1:0]  out_length;
        logic [IDX_W-1:0]  buf_index;
    } result_t;

    // Effective (clamped) configuration seen by the core
    typedef struct packed {
        logic              direct_only;
        logic [SIZE_W-1:0] win_eff;
        logic [SIZE_W-1:0] run_eff;
    } cfg_t;

endpackage

### hdl/rwb_cfg_regs.sv
// Configuration registers with window and run size clamping.
`timescale 1ns / 1ps

module rwb_cfg_regs import rwb_pkg::*; #(
    parameter int WINDOW_BYTES = 65536,
    parameter int RUN_BYTES    = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_addr,
    input  logic [SIZE_W-1:0] cfg_wdata,
    output cfg_t              cfg
);

    localparam int SIZE_MAX = (1 << SIZE_W) - 1;
    localparam int WIN_LIM  = (WINDOW_BYTES > SIZE_MAX) ? SIZE_MAX : WINDOW_BYTES;
    localparam int RUN_LIM  = (RUN_BYTES > SIZE_MAX) ? SIZE_MAX : RUN_BYTES;
    localparam logic [SIZE_W-1:0] WIN_CLAMP = SIZE_W'(WIN_LIM);
    localparam logic [SIZE_W-1:0] RUN_CLAMP = SIZE_W'(RUN_LIM);

    logic              direct_only_reg;
    logic [SIZE_W-1:0] window_size_reg;
    logic [SIZE_W-1:0] run_size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direct_only_reg <= 1'b0;
            window_size_reg <= '0;
            run_size_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_DIRECT_ONLY: direct_only_reg <= cfg_wdata[0];
                REG_WINDOW_SIZE: window_size_reg <= cfg_wdata;
                REG_RUN_SIZE:    run_size_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.direct_only = direct_only_reg;
        cfg.win_eff     = (window_size_reg < WIN_CLAMP) ? window_size_reg : WIN_CLAMP;
        cfg.run_eff     = (run_size_reg < RUN_CLAMP) ? run_size_reg : RUN_CLAMP;
    end

endmodule

### hdl/rwb_core.sv
// Input register, controller state and the per-word decision logic.
`timescale 1ns / 1ps

module rwb_core import rwb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    logic              p_valid_reg;
    item_t             item_reg;
    logic              adv;

    logic [OFF_W-1:0]  run_start_reg, run_start_next;
    logic [SIZE_W-1:0] run_length_reg, run_length_next;
    logic [OFF_W-1:0]  window_start_reg, window_start_next;
    logic [SIZE_W-1:0] window_length_reg, window_length_next;
    logic [OFF_W-1:0]  next_seq_reg, next_seq_next;
    await_t            awaiting_reg, awaiting_next;
    logic [OFF_W-1:0]  saved_off_reg, saved_off_next;
    logic [LEN_W-1:0]  saved_len_reg, saved_len_next;

    // request operands: live item, or the saved request on a reply
    logic [OFF_W-1:0]  r_off;
    logic [LEN_W-1:0]  r_len;
    logic              is_reply;

    // read path
    logic              rd_direct;
    logic              rd_hit;
    logic [OFF_W-1:0]  d_cur;
    logic [OFF_W:0]    hit_end;
    logic [LEN_W-1:0]  fill_sz;
    logic [LEN_W-1:0]  fill_got;
    logic [SIZE_W-1:0] new_wl;
    logic              is_fill_reply;

    // serve unit
    logic [OFF_W-1:0]  sv_start;
    logic [SIZE_W-1:0] sv_wl;
    logic [OFF_W-1:0]  sv_d;
    logic              sv_in;
    logic [OFF_W-1:0]  sv_inbuf;
    logic [LEN_W-1:0]  sv_avail;
    logic [IDX_W-1:0]  sv_idx;
    logic [OFF_W-1:0]  sv_next_seq;

    // write path
    logic [SIZE_W-1:0] rl;
    logic              wr_big;
    logic              wr_flush;
    logic [OFF_W-1:0]  run_end;
    logic [LEN_W:0]    run_fill;

    logic              do_read;
    logic              do_write;

    assign adv       = p_valid_reg && res_ready;
    assign in_ready  = !p_valid_reg || res_ready;
    assign res_valid = p_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    // ---------------- shared datapath ----------------
    always_comb begin
        is_reply = (item_reg.cmd == CMD_REPLY);
        r_off    = is_reply ? saved_off_reg : item_reg.offset;
        r_len    = is_reply ? saved_len_reg : item_reg.length;

        rd_direct = cfg.direct_only || (cfg.win_eff == '0) ||
                    (r_len >= LEN_W'(cfg.win_eff));
        d_cur     = r_off - window_start_reg;
        hit_end   = {1'b0, d_cur} + (OFF_W+1)'(r_len);
        rd_hit    = (window_length_reg != '0) && (r_off >= window_start_reg) &&
                    (hit_end <= (OFF_W+1)'(window_length_reg));

        fill_sz       = (r_off == next_seq_reg) ? LEN_W'(cfg.win_eff) : r_len;
        fill_got      = (item_reg.reply_count < fill_sz) ? item_reg.reply_count : fill_sz;
        new_wl        = fill_got[SIZE_W-1:0];
        is_fill_reply = is_reply && (awaiting_reg == W_FILL);

        // serve from the current window, or from the one just filled
        sv_start    = is_fill_reply ? saved_off_reg : window_start_reg;
        sv_wl       = is_fill_reply ? new_wl : window_length_reg;
        sv_d        = r_off - sv_start;
        sv_in       = (r_off >= sv_start) && (sv_d < OFF_W'(sv_wl));
        sv_inbuf    = OFF_W'(sv_wl) - sv_d;
        sv_avail    = '0;
        sv_idx      = '0;
        if (sv_in) begin
            sv_idx   = sv_d[IDX_W-1:0];
            sv_avail = (LEN_W'(sv_inbuf[SIZE_W-1:0]) < r_len) ?
                       LEN_W'(sv_inbuf[SIZE_W-1:0]) : r_len;
        end
        sv_next_seq = r_off + OFF_W'(sv_avail);

        // a write retried after its flush sees an empty run
        rl       = is_reply ? '0 : run_length_reg;
        wr_big   = (cfg.run_eff == '0) || (r_len >= LEN_W'(cfg.run_eff));
        run_end  = run_start_reg + OFF_W'(rl);
        run_fill = (LEN_W+1)'(rl) + {1'b0, r_len};
        wr_flush = (rl != '0) &&
                   ((r_off != run_end) || (run_fill > (LEN_W+1)'(cfg.run_eff)));
    end

    // ---------------- decision ----------------
    always_comb begin
        run_start_next     = run_start_reg;
        run_length_next    = run_length_reg;
        window_start_next  = window_start_reg;
        window_length_next = window_length_reg;
        next_seq_next      = next_seq_reg;
        awaiting_next      = awaiting_reg;
        saved_off_next     = saved_off_reg;
        saved_len_next     = saved_len_reg;
        do_read            = 1'b0;
        do_write           = 1'b0;

        res.action     = ACT_BUSY;
        res.out_offset = '0;
        res.out_length = '0;
        res.buf_index  = '0;

        if (!is_reply) begin
            if (awaiting_reg != W_NONE) begin
                res.action = ACT_BUSY;
            end else begin
                case (item_reg.cmd)
                    CMD_READ: begin
                        if (run_length_reg != '0) begin
                            saved_off_next = item_reg.offset;
                            saved_len_next = item_reg.length;
                            awaiting_next  = W_FLUSH_READ;
                            res.action     = ACT_BWRITE;
                            res.out_offset = run_start_reg;
                            res.out_length = LEN_W'(run_length_reg);
                        end else begin
                            do_read = 1'b1;
                        end
                    end
                    CMD_WRITE: do_write = 1'b1;
                    default: begin
                        if (run_length_reg != '0) begin
                            awaiting_next  = W_FLUSH_CMD;
                            res.action     = ACT_BWRITE;
                            res.out_offset = run_start_reg;
                            res.out_length = LEN_W'(run_length_reg);
                        end else begin
                            res.action = ACT_DONE;
                        end
                    end
                endcase
            end
        end else begin
            awaiting_next = W_NONE;
            if (awaiting_reg == W_NONE || !item_reg.reply_ok) begin
                res.action = ACT_FAIL;
            end else begin
                unique case (awaiting_reg)
                    W_FLUSH_READ: begin
                        run_length_next = '0;
                        do_read         = 1'b1;
                    end
                    W_FLUSH_WRITE: begin
                        run_length_next = '0;
                        do_write        = 1'b1;
                    end
                    W_THROUGH: res.action = ACT_DONE;
                    W_DIRECT: begin
                        res.action     = ACT_DONE;
                        res.out_length = item_reg.reply_count;
                    end
                    W_FILL: begin
                        window_start_next  = saved_off_reg;
                        window_length_next = new_wl;
                        next_seq_next      = sv_next_seq;
                        res.action         = ACT_SERVE;
                        res.out_offset     = r_off;
                        res.out_length     = sv_avail;
                        res.buf_index      = sv_idx;
                    end
                    W_FLUSH_CMD: begin
                        run_length_next = '0;
                        res.action      = ACT_DONE;
                    end
                    default: res.action = ACT_FAIL;
                endcase
            end
        end

        if (do_read) begin
            saved_off_next = r_off;
            saved_len_next = r_len;
            if (rd_direct) begin
                awaiting_next  = W_DIRECT;
                res.action     = ACT_DREAD;
                res.out_offset = r_off;
                res.out_length = r_len;
            end else if (rd_hit) begin
                next_seq_next  = sv_next_seq;
                res.action     = ACT_SERVE;
                res.out_offset = r_off;
                res.out_length = sv_avail;
                res.buf_index  = sv_idx;
            end else begin
                awaiting_next  = W_FILL;
                res.action     = ACT_FILL;
                res.out_offset = r_off;
                res.out_length = fill_sz;
            end
        end

        if (do_write) begin
            saved_off_next = r_off;
            saved_len_next = r_len;
            if (wr_big || wr_flush) begin
                res.action = ACT_BWRITE;
                if (rl != '0) begin
                    awaiting_next  = W_FLUSH_WRITE;
                    res.out_offset = run_start_reg;
                    res.out_length = LEN_W'(rl);
                end else begin
                    awaiting_next  = W_THROUGH;
                    res.out_offset = r_off;
                    res.out_length = r_len;
                end
            end else begin
                if (rl == '0) begin
                    run_start_next = r_off;
                end
                run_length_next = rl + r_len[SIZE_W-1:0];
                res.action      = ACT_STASH;
                res.out_offset  = r_off;
                res.out_length  = r_len;
                res.buf_index   = rl[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_start_reg     <= '0;
            run_length_reg    <= '0;
            window_start_reg  <= '0;
            window_length_reg <= '0;
            next_seq_reg      <= '0;
            awaiting_reg      <= W_NONE;
            saved_off_reg     <= '0;
            saved_len_reg     <= '0;
        end else if (adv) begin
            run_start_reg     <= run_start_next;
            run_length_reg    <= run_length_next;
            window_start_reg  <= window_start_next;
            window_length_reg <= window_length_next;
            next_seq_reg      <= next_seq_next;
            awaiting_reg      <= awaiting_next;
            saved_off_reg     <= saved_off_next;
            saved_len_reg     <= saved_len_next;
        end
    end

endmodule

### hdl/rwb_out_reg.sv
// Result register in front of the master-side stream.
`timescale 1ns / 1ps

module rwb_out_reg import rwb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    valid_reg;
    result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

### hdl/readahead_writeback_buffer_ctrl.sv
// Top level of the read-ahead window and write-combining run controller.
`timescale 1ns / 1ps

// Controller for one file handle's read-ahead window and write-combining run.
// Each input word (read, write, flush request, or backend reply) produces
// exactly one result word naming the next action: backend write, direct
// read, window fill, serve from a window index, stash at a run index, done,
// fail or busy. Requests that arrive while a backend reply is pending get
// busy; a reply with nothing pending gets fail. Throughput is one word per
// clock unless m_tready stalls: a word sits in the input register while the
// decision logic (a few 63-bit subtracts and compares against the window
// and run bounds) computes its result and state update, and the result
// lands in the output register. Between s_ acceptance and m_tvalid the word
// passes through the input register and then the result register.
// Backpressure on m_tready stalls the input register, which then stalls
// s_tready. Configuration (cfg_addr 0 direct_only, 1 window_size,
// 2 run_size) must only be written while no word is in flight; the port is
// always ready. Effective sizes are min(register, WINDOW_BYTES/RUN_BYTES).
module readahead_writeback_buffer_ctrl import rwb_pkg::*; #(
    parameter int WINDOW_BYTES = 65536,
    parameter int RUN_BYTES    = 65536
) (
    input  logic          aclk,
    input  logic          aresetn,

    input  logic          s_tvalid,
    output logic          s_tready,
    // [62:0] offset, [94:63] length, [95] reply_ok, [127:96] reply_count
    input  logic [127:0]  s_tdata,
    // [1:0] cmd
    input  logic [1:0]    s_tuser,

    output logic          m_tvalid,
    input  logic          m_tready,
    // [62:0] out_offset, [94:63] out_length, [110:95] buf_index, [111] zero
    output logic [111:0]  m_tdata,
    // [2:0] action
    output logic [2:0]    m_tuser,

    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_addr,
    input  logic [16:0]   cfg_wdata
);

    cfg_t    cfg;
    item_t   in_item;
    logic    res_valid;
    logic    res_ready;
    result_t res;
    result_t out_res;

    // unpack the incoming word
    always_comb begin
        in_item.cmd         = cmd_t'(s_tuser);
        in_item.offset      = s_tdata[62:0];
        in_item.length      = s_tdata[94:63];
        in_item.reply_ok    = s_tdata[95];
        in_item.reply_count = s_tdata[127:96];
    end

    rwb_cfg_regs #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .RUN_BYTES    (RUN_BYTES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rwb_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    rwb_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_res    (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack the result word
    assign m_tuser = out_res.action;
    assign m_tdata = {1'b0, out_res.buf_index, out_res.out_length, out_res.out_offset};

endmodule

### sim/rwb_action_checker.sv
// Checker: predicts one action word per accepted input word and compares it with the output.
`timescale 1ns / 1ps

module rwb_action_checker import rwb_pkg::*; #(
    parameter int WINDOW_BYTES = 65536,
    parameter int RUN_BYTES    = 65536
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    input  logic          s_tready,
    input  logic [127:0]  s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          m_tvalid,
    input  logic          m_tready,
    input  logic [111:0]  m_tdata,
    input  logic [2:0]    m_tuser,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [1:0]    cfg_addr,
    input  logic [16:0]   cfg_wdata,
    output logic          reply_pending,
    output int            actions_owed,
    output int            mismatches
);

    typedef struct packed {
        logic              direct_only;
        logic [16:0]       win_sz;
        logic [16:0]       run_sz;
        logic [62:0]       run_start;
        logic [16:0]       run_len;
        logic [62:0]       win_start;
        logic [16:0]       win_len;
        logic [62:0]       next_seq;
        await_t            awaiting;
        logic [62:0]       saved_off;
        logic [31:0]       saved_len;
    } buf_state_t;

    typedef struct packed {
        buf_state_t        st;
        result_t           res;
    } decision_t;

    buf_state_t ctl;
    item_t      word_in;
    decision_t  decided;
    result_t    due_actions[$];

    function automatic result_t act(action_t a, logic [62:0] off, logic [31:0] len,
                                    logic [15:0] idx);
        result_t r;
        r.action     = a;
        r.out_offset = off;
        r.out_length = len;
        r.buf_index  = idx;
        return r;
    endfunction

    // Next state and action word for one input word.
    function automatic decision_t next_action(buf_state_t m, item_t w);
        decision_t   d;
        logic [63:0] off, n, ws, rs, lim, rel, avail, idx, cnt;
        logic [62:0] run_end;
        logic        do_read, do_write, do_serve;
        d.st     = m;
        d.res    = act(ACT_FAIL, '0, '0, '0);
        off      = {1'b0, w.offset};
        n        = {32'd0, w.length};
        cnt      = {32'd0, w.reply_count};
        ws       = (m.win_sz < WINDOW_BYTES) ? {47'd0, m.win_sz} : 64'(WINDOW_BYTES);
        rs       = (m.run_sz < RUN_BYTES) ? {47'd0, m.run_sz} : 64'(RUN_BYTES);
        do_read  = 1'b0;
        do_write = 1'b0;
        do_serve = 1'b0;

        if (w.cmd != CMD_REPLY) begin
            if (m.awaiting != W_NONE) begin
                d.res = act(ACT_BUSY, '0, '0, '0);
            end else if (w.cmd == CMD_READ && m.run_len != 0) begin
                // pending run goes out before the read is looked at
                d.st.saved_off = w.offset;
                d.st.saved_len = w.length;
                d.st.awaiting  = W_FLUSH_READ;
                d.res = act(ACT_BWRITE, m.run_start, 32'(m.run_len), '0);
            end else if (w.cmd == CMD_READ) begin
                do_read = 1'b1;
            end else if (w.cmd == CMD_WRITE) begin
                do_write = 1'b1;
            end else if (m.run_len != 0) begin
                d.st.awaiting = W_FLUSH_CMD;
                d.res = act(ACT_BWRITE, m.run_start, 32'(m.run_len), '0);
            end else begin
                d.res = act(ACT_DONE, '0, '0, '0);
            end
        end else begin
            // fail stands unless a reply was awaited and it succeeded
            d.st.awaiting = W_NONE;
            off = {1'b0, m.saved_off};
            n   = {32'd0, m.saved_len};
            if (w.reply_ok) begin
                case (m.awaiting)
                    W_FLUSH_READ: begin
                        d.st.run_len = '0;
                        do_read = 1'b1;
                    end
                    W_FLUSH_WRITE: begin
                        d.st.run_len = '0;
                        do_write = 1'b1;
                    end
                    W_THROUGH: d.res = act(ACT_DONE, '0, '0, '0);
                    W_DIRECT:  d.res = act(ACT_DONE, '0, w.reply_count, '0);
                    W_FILL: begin
                        lim = (m.saved_off == m.next_seq) ? ws : n;
                        d.st.win_start = m.saved_off;
                        d.st.win_len   = (cnt < lim) ? cnt[16:0] : lim[16:0];
                        do_serve = 1'b1;
                    end
                    W_FLUSH_CMD: begin
                        d.st.run_len = '0;
                        d.res = act(ACT_DONE, '0, '0, '0);
                    end
                    default: ;
                endcase
            end
        end

        if (do_read) begin
            d.st.saved_off = off[62:0];
            d.st.saved_len = n[31:0];
            if (m.direct_only || ws == 0 || n >= ws) begin
                d.st.awaiting = W_DIRECT;
                d.res = act(ACT_DREAD, off[62:0], n[31:0], '0);
            end else if (d.st.win_len != 0 && off >= {1'b0, d.st.win_start} &&
                         off - {1'b0, d.st.win_start} + n <= {47'd0, d.st.win_len}) begin
                do_serve = 1'b1;
            end else begin
                // sequential miss fetches the whole window
                d.st.awaiting = W_FILL;
                lim = (off[62:0] == m.next_seq) ? ws : n;
                d.res = act(ACT_FILL, off[62:0], lim[31:0], '0);
            end
        end

        if (do_write) begin
            d.st.saved_off = off[62:0];
            d.st.saved_len = n[31:0];
            run_end = d.st.run_start + 63'(d.st.run_len);
            if (rs == 0 || n >= rs) begin
                if (d.st.run_len != 0) begin
                    d.st.awaiting = W_FLUSH_WRITE;
                    d.res = act(ACT_BWRITE, d.st.run_start, 32'(d.st.run_len), '0);
                end else begin
                    d.st.awaiting = W_THROUGH;
                    d.res = act(ACT_BWRITE, off[62:0], n[31:0], '0);
                end
            end else if (d.st.run_len != 0 && (off[62:0] != run_end ||
                         {47'd0, d.st.run_len} + n > rs)) begin
                d.st.awaiting = W_FLUSH_WRITE;
                d.res = act(ACT_BWRITE, d.st.run_start, 32'(d.st.run_len), '0);
            end else begin
                if (d.st.run_len == 0)
                    d.st.run_start = off[62:0];
                d.res = act(ACT_STASH, off[62:0], n[31:0], d.st.run_len[15:0]);
                d.st.run_len = d.st.run_len + n[16:0];
            end
        end

        if (do_serve) begin
            avail = '0;
            idx   = '0;
            if (off >= {1'b0, d.st.win_start} &&
                off - {1'b0, d.st.win_start} < {47'd0, d.st.win_len}) begin
                idx   = off - {1'b0, d.st.win_start};
                rel   = {47'd0, d.st.win_len} - idx;
                avail = (rel < n) ? rel : n;
            end
            d.st.next_seq = off[62:0] + avail[62:0];
            d.res = act(ACT_SERVE, off[62:0], avail[31:0], idx[15:0]);
        end
        return d;
    endfunction

    always_comb begin
        word_in.cmd         = cmd_t'(s_tuser);
        word_in.offset      = s_tdata[62:0];
        word_in.length      = s_tdata[94:63];
        word_in.reply_ok    = s_tdata[95];
        word_in.reply_count = s_tdata[127:96];
        decided = next_action(ctl, word_in);
        // state after the word being taken at this edge, if any
        reply_pending = (s_tvalid && s_tready) ? (decided.st.awaiting != W_NONE)
                                               : (ctl.awaiting != W_NONE);
    end

    task automatic match_field(string what, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        buf_state_t nxt;
        result_t    want;
        nxt = ctl;
        if (!aresetn) begin
            nxt = '0;
            nxt.awaiting = W_NONE;
            due_actions.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (due_actions.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word, expected none got action %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = due_actions.pop_front();
                    match_field("action", 64'(want.action), 64'(m_tuser));
                    match_field("out_offset", 64'(want.out_offset), 64'(m_tdata[62:0]));
                    match_field("out_length", 64'(want.out_length), 64'(m_tdata[94:63]));
                    match_field("buf_index", 64'(want.buf_index), 64'(m_tdata[110:95]));
                    match_field("pad bit", 64'd0, 64'(m_tdata[111]));
                end
            end
            if (s_tvalid && s_tready) begin
                nxt = decided.st;
                due_actions.push_back(decided.res);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_addr)
                    REG_DIRECT_ONLY: nxt.direct_only = cfg_wdata[0];
                    REG_WINDOW_SIZE: nxt.win_sz      = cfg_wdata;
                    REG_RUN_SIZE:    nxt.run_sz      = cfg_wdata;
                    default: ;
                endcase
            end
        end
        ctl <= nxt;
        actions_owed = due_actions.size();
    end

endmodule

### sim/readahead_writeback_buffer_ctrl_tb.sv
// Testbench top: clock, reset, stimulus and verdict for the buffer controller.
`timescale 1ns / 1ps

// Stimulus is a directed sequence that walks through every action and the
// corner cases (busy, stray reply, failed reply, oversized and empty fills,
// offset wrap on a contiguous run, config change while a flush is out, run
// larger than a shrunk run size), then random phases, each of which sets its
// configuration. The checker predicts every action word; this module only
// drives the channels and reports the verdict.
module readahead_writeback_buffer_ctrl_tb;
    import rwb_pkg::*;

    localparam int          WINDOW_BYTES    = 65536;
    localparam int          RUN_BYTES       = 65536;
    localparam int          PHASES          = 10;
    localparam int          WORDS_PER_PHASE = 140;
    // bound far above the slowest run, drains included
    localparam int          CYCLE_LIMIT     = 400000;
    localparam logic [62:0] OFF_MAX         = '1;
    localparam logic [31:0] LEN_MAX         = '1;

    logic          aclk;
    logic          aresetn;
    logic          s_tvalid;
    logic          s_tready;
    // [62:0] offset, [94:63] length, [95] reply_ok, [127:96] reply_count
    logic [127:0]  s_tdata;
    // [1:0] cmd
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    // [62:0] out_offset, [94:63] out_length, [110:95] buf_index, [111] zero
    logic [111:0]  m_tdata;
    // [2:0] action
    logic [2:0]    m_tuser;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_addr;
    logic [16:0]   cfg_wdata;

    logic          reply_pending;
    int            actions_owed;
    int            mismatches;
    int            cycles = 0;
    bit            calm = 1'b0;       // no idling on either side while set
    logic [62:0]   rd_cur = 63'h100000;
    logic [62:0]   wr_cur = 63'h0;
    int            rd_span = 64;
    int            wr_span = 64;
    logic [16:0]   size_steps [7] = '{17'd0, 17'd16, 17'd64, 17'd300, 17'd4096,
                                      17'd65535, 17'd65536};

    readahead_writeback_buffer_ctrl #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .RUN_BYTES    (RUN_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rwb_action_checker #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .RUN_BYTES    (RUN_BYTES)
    ) i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .reply_pending (reply_pending),
        .actions_owed  (actions_owed),
        .mismatches    (mismatches)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall before each word, none while calm is set
    initial begin
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    function automatic logic [62:0] rand_off();
        return 63'({$urandom, $urandom});
    endfunction

    // One input word; returns at the edge that takes it. tvalid stays high
    // into the next word when no gap is drawn.
    task automatic send(cmd_t c, logic [62:0] off, logic [31:0] len, logic ok,
                        logic [31:0] cnt);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= {cnt, ok, len, off};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the input until every predicted word is out, then let the pipe settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (actions_owed != 0) @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes all three registers back to back; block must be idle.
    task automatic set_config(logic direct, logic [16:0] win, logic [16:0] run);
        cfg_valid <= 1'b1;
        cfg_addr  <= REG_DIRECT_ONLY;
        cfg_wdata <= {16'd0, direct};
        do @(posedge aclk); while (!cfg_ready);
        cfg_addr  <= REG_WINDOW_SIZE;
        cfg_wdata <= win;
        do @(posedge aclk); while (!cfg_ready);
        cfg_addr  <= REG_RUN_SIZE;
        cfg_wdata <= run;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rd_span = (win != 0) ? int'(win) : 64;
        wr_span = (run != 0) ? int'(run) : 64;
    endtask

    // Mostly well-formed traffic: replies when one is awaited, sequential
    // reads and contiguous writes; the rest is busy hits, stray replies and
    // random offsets and lengths.
    task automatic random_word();
        logic [62:0] off;
        logic [31:0] len, cnt;
        int          r;
        r = $urandom_range(0, 99);
        if (reply_pending && r < 90) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                cnt = $urandom_range(0, rd_span + 8);
            else if (r == 7)
                cnt = '0;
            else
                cnt = $urandom;
            send(CMD_REPLY, rand_off(), $urandom, $urandom_range(0, 15) != 0, cnt);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                r = $urandom_range(0, 9);
                len = $urandom_range(0, rd_span - 1);
                if (r < 6)
                    off = rd_cur;
                else if (r < 8)
                    off = rd_cur - 63'($urandom_range(0, rd_span));
                else
                    off = rand_off();
                if (r == 9)
                    len = $urandom;
                send(CMD_READ, off, len, 1'($urandom), $urandom);
                if (r < 6)
                    rd_cur = off + 63'(len);
            end else if (r < 85) begin
                r = $urandom_range(0, 9);
                len = $urandom_range(0, wr_span / 2);
                off = (r < 7) ? wr_cur : rand_off();
                if (r == 8)
                    len = $urandom_range(wr_span, wr_span * 2);
                if (r == 9)
                    len = $urandom;
                send(CMD_WRITE, off, len, 1'($urandom), $urandom);
                if (r < 7)
                    wr_cur = off + 63'(len);
            end else if (r < 95) begin
                send(CMD_FLUSH, rand_off(), $urandom, 1'($urandom), $urandom);
            end else begin
                send(CMD_REPLY, rand_off(), $urandom, 1'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= CMD_READ;
        cfg_valid <= 1'b0;
        cfg_addr  <= REG_DIRECT_ONLY;
        cfg_wdata <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // ---- directed ----
        set_config(1'b0, 17'd64, 17'd32);
        send(CMD_READ, 63'd0, 32'd8, 1'b0, '0);        // sequential miss: fill 64
        send(CMD_READ, 63'd0, 32'd8, 1'b0, '0);        // busy while fill is out
        send(CMD_REPLY, '0, '0, 1'b1, 32'd100);        // fill gave too much: capped
        send(CMD_READ, 63'd8, 32'd16, 1'b0, '0);       // window hit
        send(CMD_READ, 63'd60, 32'd10, 1'b0, '0);      // non-sequential miss
        send(CMD_REPLY, '0, '0, 1'b1, 32'd0);          // empty fill: serve 0 bytes
        send(CMD_WRITE, 63'd1000, 32'd10, 1'b0, '0);   // stash at 0
        send(CMD_WRITE, 63'd1010, 32'd10, 1'b0, '0);   // stash at 10
        send(CMD_WRITE, 63'd5000, 32'd4, 1'b0, '0);    // gap: flush the run
        send(CMD_REPLY, '0, '0, 1'b1, '0);             // then stash
        send(CMD_WRITE, 63'd5004, 32'd30, 1'b0, '0);   // won't fit: flush
        send(CMD_REPLY, OFF_MAX, LEN_MAX, 1'b0, LEN_MAX); // backend error, run kept
        send(CMD_REPLY, '0, '0, 1'b1, '0);             // stray reply
        send(CMD_FLUSH, '0, '0, 1'b0, '0);             // flush the kept run
        send(CMD_REPLY, '0, '0, 1'b1, '0);
        send(CMD_FLUSH, '0, '0, 1'b0, '0);             // nothing to flush
        send(CMD_WRITE, 63'd0, LEN_MAX, 1'b0, '0);     // write-through
        send(CMD_REPLY, '0, '0, 1'b1, '0);
        send(CMD_READ, OFF_MAX, LEN_MAX, 1'b0, '0);    // too big for window: direct
        send(CMD_REPLY, '0, '0, 1'b1, LEN_MAX);
        send(CMD_WRITE, OFF_MAX, 32'd1, 1'b0, '0);     // run at the top offset
        send(CMD_WRITE, 63'd0, 32'd1, 1'b0, '0);       // wraps to 0: still contiguous
        send(CMD_READ, 63'd100, 32'd4, 1'b0, '0);      // read flushes run first
        drain();
        set_config(1'b1, 17'd64, 17'd32);              // change while flush is out
        send(CMD_REPLY, '0, '0, 1'b1, '0);             // read now goes direct
        send(CMD_REPLY, '0, '0, 1'b1, 32'd4);
        drain();
        set_config(1'b0, 17'd64, 17'd32);
        send(CMD_WRITE, 63'd2000, 32'd20, 1'b0, '0);
        drain();
        set_config(1'b0, 17'd64, 17'd16);              // run now longer than run size
        send(CMD_WRITE, 63'd2020, 32'd2, 1'b0, '0);
        send(CMD_REPLY, '0, '0, 1'b1, '0);

        // ---- random phases, every size step and both direct_only values ----
        for (int p = 0; p < PHASES; p++) begin
            drain();
            set_config(p == 3 || p == 8, size_steps[p % 7], size_steps[(p * 3 + 2) % 7]);
            calm = (p % 4 == 1);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if ($urandom_range(0, 199) == 0)
                    drain();
                random_word();
            end
        end

        drain();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
